FILE: src/assert_macros.svh
// Assertion macros shared by the LED strip effect generator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CHK_IMPLIES(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define CHK_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

FILE: src/lseg_pkg.sv
// Types, constants and color functions of the LED strip effect generator
package lseg_pkg;

    localparam int unsigned MAX_PIXELS_DEF = 64;
    localparam int unsigned IDX_W          = 6;
    localparam int unsigned COUNT_W        = 7;
    localparam int unsigned MODE_W         = 3;
    localparam int unsigned CHAN_W         = 8;
    localparam int unsigned COLOR_W        = 32;
    localparam int unsigned CFG_IDX_W      = 2;
    localparam int unsigned CFG_DATA_W     = 32;
    localparam int unsigned DIV_STEPS      = 9;   // bits of the dividend 256
    localparam int unsigned DIV_CNT_W      = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT = 2'd3;

    // effect modes
    localparam logic [MODE_W-1:0] MODE_RAINBOW  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CYCLE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CHASE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CHASE_RB = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STROBE   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PULSE    = 3'd5;

    localparam logic [7:0] WHEEL_SEG1  = 8'd85;
    localparam logic [7:0] WHEEL_SEG2  = 8'd170;
    localparam logic [7:0] FULL_SCALE  = 8'd255;
    localparam logic [5:0] PULSE_MID   = 6'd19;
    localparam logic [5:0] PULSE_LAST  = 6'd37;
    localparam logic [7:0] PULSE_GAIN  = 8'(255 / 20);
    localparam logic [7:0] HUE255_LAST = 8'd254;
    localparam logic [1:0] CHASE_LAST  = 2'd2;

    localparam logic [COUNT_W-1:0] RESET_COUNT  = 7'd64;
    localparam logic [7:0]         RESET_BRIGHT = 8'd255;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_DIV,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic setup;     // load frame setup, reset pixel walk
        logic restart;   // clear effect counters during setup
        logic div_step;  // one step of the 256/count divider
        logic issue;     // launch one pixel into the pipe
        logic finish;    // advance effect counters at frame end
    } cmd_t;

    typedef struct packed {
        logic adv;         // pipe can take a pixel
        logic div_last;    // divider on its final step
        logic pix_last;    // current pixel is the last one
        logic count_zero;  // empty strip, no pixels this frame
    } sts_t;

    function automatic logic [COLOR_W-1:0] wheel(input logic [7:0] p);
        logic [7:0] q;
        logic [7:0] up;
        logic [7:0] dn;
        if (p < WHEEL_SEG1) begin
            q = p;
        end else if (p < WHEEL_SEG2) begin
            q = p - WHEEL_SEG1;
        end else begin
            q = p - WHEEL_SEG2;
        end
        up = 8'(q * 3);
        dn = FULL_SCALE - up;
        if (p < WHEEL_SEG1) begin
            return {up, dn, 8'd0, 8'd0};
        end else if (p < WHEEL_SEG2) begin
            return {dn, 8'd0, up, 8'd0};
        end
        return {8'd0, up, dn, 8'd0};
    endfunction

    // per channel (c * f) >> 8
    function automatic logic [COLOR_W-1:0] scale(input logic [COLOR_W-1:0] color,
                                                 input logic [7:0] f);
        logic [COLOR_W-1:0] res;
        logic [15:0]        prod;
        res = '0;
        for (int k = 0; k < 4; k++) begin
            prod = color[8*k +: 8] * f;
            res[8*k +: 8] = prod[15:8];
        end
        return res;
    endfunction

endpackage

FILE: src/lseg_ctrl.sv
// Frame sequencer of the LED strip effect generator
`include "assert_macros.svh"

module lseg_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_restart,
    input  lseg_pkg::sts_t    sts,
    output lseg_pkg::cmd_t    cmd
);

    lseg_pkg::state_t state_reg, state_next;
    logic             restart_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lseg_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            restart_reg <= s_restart;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            lseg_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = lseg_pkg::ST_CLEAR;
                end
            end
            lseg_pkg::ST_CLEAR: begin
                cmd.setup   = 1'b1;
                cmd.restart = restart_reg;
                state_next  = lseg_pkg::ST_DIV;
            end
            lseg_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = sts.count_zero ? lseg_pkg::ST_DONE : lseg_pkg::ST_RUN;
                end
            end
            lseg_pkg::ST_RUN: begin
                if (sts.adv) begin
                    cmd.issue = 1'b1;
                    if (sts.pix_last) begin
                        state_next = lseg_pkg::ST_DONE;
                    end
                end
            end
            lseg_pkg::ST_DONE: begin
                cmd.finish = 1'b1;
                state_next = lseg_pkg::ST_IDLE;
            end
            default: begin
                state_next = lseg_pkg::ST_IDLE;
            end
        endcase
    end

    `CHK_NEXT(a_accept_setup, aclk, aresetn, s_valid && s_ready, state_reg == lseg_pkg::ST_CLEAR)
    `CHK_NEXT(a_finish_ready, aclk, aresetn, cmd.finish, s_ready)

endmodule

FILE: src/lseg_dp.sv
// Datapath of the LED strip effect generator: registers, counters, divider, pixel pipe
`include "assert_macros.svh"

module lseg_dp #(
    parameter int unsigned MAX_PIXELS = lseg_pkg::MAX_PIXELS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [lseg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lseg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  lseg_pkg::cmd_t                    cmd,
    output lseg_pkg::sts_t                    sts,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lseg_pkg::IDX_W-1:0]        m_pixel_index,
    output logic [lseg_pkg::CHAN_W-1:0]       m_red_level,
    output logic [lseg_pkg::CHAN_W-1:0]       m_green_level,
    output logic [lseg_pkg::CHAN_W-1:0]       m_blue_level,
    output logic [lseg_pkg::CHAN_W-1:0]       m_white_level,
    output logic                              m_last_pixel
);

    localparam int unsigned CW = lseg_pkg::COUNT_W;
    localparam int unsigned IW = lseg_pkg::IDX_W;
    localparam int unsigned XW = lseg_pkg::COLOR_W;

    // configuration
    logic [lseg_pkg::MODE_W-1:0] mode_reg;
    logic [CW-1:0]               pixel_count_reg;
    logic [XW-1:0]               color_reg;
    logic [7:0]                  bright_reg;

    // effect counters
    logic [7:0] hue_reg, hue_next;
    logic [7:0] hue255_reg, hue255_next;
    logic [1:0] phase_reg, phase_next;
    logic [5:0] pulse_reg, pulse_next;

    // frame setup and divider
    logic [CW-1:0]                  count_eff_reg;
    logic [CW-1:0]                  count_clamp;
    logic [CW-1:0]                  div_rem_reg, div_rem_next;
    logic [8:0]                     div_quo_reg;
    logic [lseg_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [CW-1:0]                  rem_sh;
    logic                           rem_ge;

    // pixel walk
    logic [IW-1:0] pix_idx_reg;
    logic [1:0]    mod3_reg;
    logic [7:0]    qacc_reg;
    logic [CW-1:0] racc_reg;
    logic [CW-1:0] rsum;
    logic          carry;

    logic [XW-1:0] pulse_color_reg;
    logic [5:0]    pulse_dist;
    logic [7:0]    pulse_level;

    // pipe stage A: raw color
    logic          a_valid_reg;
    logic [XW-1:0] a_color_reg;
    logic [IW-1:0] a_idx_reg;
    logic          a_last_reg;
    logic [XW-1:0] pix_color;
    logic [8:0]    chase_sum;
    logic [7:0]    chase_hue;
    logic          lit;

    // output stage
    logic          m_valid_reg;
    logic [XW-1:0] m_color_reg;
    logic [IW-1:0] m_idx_reg;
    logic          m_last_reg;
    logic [XW-1:0] bright_color;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= lseg_pkg::MODE_RAINBOW;
            pixel_count_reg <= lseg_pkg::RESET_COUNT;
            color_reg       <= '0;
            bright_reg      <= lseg_pkg::RESET_BRIGHT;
        end else if (cfg_we) begin
            case (cfg_index)
                lseg_pkg::CFG_MODE:   mode_reg        <= cfg_wdata[lseg_pkg::MODE_W-1:0];
                lseg_pkg::CFG_COUNT:  pixel_count_reg <= cfg_wdata[CW-1:0];
                lseg_pkg::CFG_COLOR:  color_reg       <= cfg_wdata[XW-1:0];
                lseg_pkg::CFG_BRIGHT: bright_reg      <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // counter updates: clear/chase step at setup, advance at frame end
    always_comb begin
        hue_next    = hue_reg;
        hue255_next = hue255_reg;
        phase_next  = phase_reg;
        pulse_next  = pulse_reg;
        if (cmd.setup) begin
            if (cmd.restart) begin
                hue_next    = '0;
                hue255_next = '0;
                phase_next  = '0;
                pulse_next  = '0;
            end
            if (mode_reg == lseg_pkg::MODE_CHASE || mode_reg == lseg_pkg::MODE_CHASE_RB) begin
                phase_next = (phase_next >= lseg_pkg::CHASE_LAST) ? 2'd0 : phase_next + 2'd1;
            end
        end else if (cmd.finish) begin
            hue_next    = hue_reg + 8'd1;
            hue255_next = (hue255_reg >= lseg_pkg::HUE255_LAST) ? 8'd0 : hue255_reg + 8'd1;
            pulse_next  = (pulse_reg >= lseg_pkg::PULSE_LAST) ? 6'd0 : pulse_reg + 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hue_reg    <= '0;
            hue255_reg <= '0;
            phase_reg  <= '0;
            pulse_reg  <= '0;
        end else begin
            hue_reg    <= hue_next;
            hue255_reg <= hue255_next;
            phase_reg  <= phase_next;
            pulse_reg  <= pulse_next;
        end
    end

    assign count_clamp = (pixel_count_reg > CW'(MAX_PIXELS)) ? CW'(MAX_PIXELS) : pixel_count_reg;

    // restoring divider for 256 / count, dividend fed MSB first
    assign rem_sh       = {div_rem_reg[CW-2:0], (div_cnt_reg == '0)};
    assign rem_ge       = (rem_sh >= count_eff_reg);
    assign div_rem_next = rem_ge ? rem_sh - count_eff_reg : rem_sh;

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            count_eff_reg <= count_clamp;
            div_rem_reg   <= '0;
            div_quo_reg   <= '0;
            div_cnt_reg   <= '0;
        end else if (cmd.div_step) begin
            div_rem_reg <= div_rem_next;
            div_quo_reg <= {div_quo_reg[7:0], rem_ge};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // running floor(i*256/count) mod 256, remainder kept below count
    assign rsum  = racc_reg + div_rem_reg;
    assign carry = (rsum >= count_eff_reg);

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            pix_idx_reg <= '0;
            mod3_reg    <= '0;
            qacc_reg    <= '0;
            racc_reg    <= '0;
        end else if (cmd.issue) begin
            pix_idx_reg <= pix_idx_reg + 1'b1;
            mod3_reg    <= (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
            qacc_reg    <= qacc_reg + div_quo_reg[7:0] + {7'd0, carry};
            racc_reg    <= carry ? rsum - count_eff_reg : rsum;
        end
    end

    // pulse color is the same for every pixel of a frame
    assign pulse_dist  = (pulse_reg > lseg_pkg::PULSE_MID) ? pulse_reg - lseg_pkg::PULSE_MID
                                                           : lseg_pkg::PULSE_MID - pulse_reg;
    assign pulse_level = 8'(({2'd0, pulse_dist} + 8'd1) * lseg_pkg::PULSE_GAIN);

    always_ff @(posedge aclk) begin
        pulse_color_reg <= lseg_pkg::scale(color_reg, pulse_level);
    end

    // mod 255 hue for chase rainbow, sum stays below 2*255
    assign chase_sum = {3'd0, pix_idx_reg} + {1'b0, hue255_reg};
    assign chase_hue = (chase_sum >= 9'd255) ? 8'(chase_sum - 9'd255) : chase_sum[7:0];
    assign lit       = (mod3_reg == phase_reg);

    always_comb begin
        case (mode_reg)
            lseg_pkg::MODE_RAINBOW:  pix_color = lseg_pkg::wheel({2'd0, pix_idx_reg} + hue_reg);
            lseg_pkg::MODE_CYCLE:    pix_color = lseg_pkg::wheel(qacc_reg + hue_reg);
            lseg_pkg::MODE_CHASE:    pix_color = lit ? color_reg : '0;
            lseg_pkg::MODE_CHASE_RB: pix_color = lit ? lseg_pkg::wheel(chase_hue) : '0;
            lseg_pkg::MODE_STROBE:   pix_color = hue_reg[0] ? '0 : color_reg;
            lseg_pkg::MODE_PULSE:    pix_color = pulse_color_reg;
            default:                 pix_color = '0;
        endcase
    end

    assign sts.adv        = !m_valid_reg || m_ready;
    assign sts.div_last   = (div_cnt_reg == lseg_pkg::DIV_CNT_W'(lseg_pkg::DIV_STEPS - 1));
    assign sts.pix_last   = (({1'b0, pix_idx_reg} + 7'd1) == count_eff_reg);
    assign sts.count_zero = (count_eff_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (sts.adv) begin
            a_valid_reg <= cmd.issue;
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            a_color_reg <= pix_color;
            a_idx_reg   <= pix_idx_reg;
            a_last_reg  <= sts.pix_last;
        end
    end

    assign bright_color = (bright_reg == lseg_pkg::FULL_SCALE) ? a_color_reg
                                                               : lseg_pkg::scale(a_color_reg, bright_reg);

    always_ff @(posedge aclk) begin
        if (sts.adv) begin
            m_color_reg <= bright_color;
            m_idx_reg   <= a_idx_reg;
            m_last_reg  <= a_last_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_index = m_idx_reg;
    assign m_red_level   = m_color_reg[31:24];
    assign m_green_level = m_color_reg[23:16];
    assign m_blue_level  = m_color_reg[15:8];
    assign m_white_level = m_color_reg[7:0];
    assign m_last_pixel  = m_last_reg;

    `CHK_NEXT(a_pix_step, aclk, aresetn, cmd.issue && !sts.pix_last, pix_idx_reg == $past(pix_idx_reg) + 6'd1)
    `CHK_IMPLIES(a_rem_low, aclk, aresetn, cmd.issue, racc_reg < count_eff_reg)

endmodule

FILE: src/led_strip_effect_generator.sv
// Top level of the LED strip effect generator
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    s_restart (one word per frame tick)
//   m_        out        m_valid/m_ready    pixel index, RGBW levels, last flag
//   cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// A frame tick runs in order: frame setup, the nine steps of the bit-serial 256/count
// divider, one pixel per cycle while the output does not stall, then an advance of the
// effect counters.
// Two-stage output pipe; m_ready low with m_valid high holds the pipe and the pixel walk.
// aresetn is synchronous; it resets the sequencer, counters and config registers.
// s_ready is high only between frames; a word may wait in the pipe while the next is taken.
module led_strip_effect_generator #(
    parameter int unsigned MAX_PIXELS = lseg_pkg::MAX_PIXELS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [lseg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lseg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_restart,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lseg_pkg::IDX_W-1:0]        m_pixel_index,
    output logic [lseg_pkg::CHAN_W-1:0]       m_red_level,
    output logic [lseg_pkg::CHAN_W-1:0]       m_green_level,
    output logic [lseg_pkg::CHAN_W-1:0]       m_blue_level,
    output logic [lseg_pkg::CHAN_W-1:0]       m_white_level,
    output logic                              m_last_pixel
);

    lseg_pkg::cmd_t cmd;
    lseg_pkg::sts_t sts;

    lseg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_restart (s_restart),
        .sts       (sts),
        .cmd       (cmd)
    );

    lseg_dp #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .cmd           (cmd),
        .sts           (sts),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_index (m_pixel_index),
        .m_red_level   (m_red_level),
        .m_green_level (m_green_level),
        .m_blue_level  (m_blue_level),
        .m_white_level (m_white_level),
        .m_last_pixel  (m_last_pixel)
    );

endmodule

FILE: verif/led_strip_effect_generator_tb.sv
// Self-checking testbench: directed table and random frame ticks against a pixel predictor
module led_strip_effect_generator_tb;
    import lseg_pkg::*;

    localparam int unsigned CLK_HALF = 6;
    localparam int unsigned SETTLE   = 100;   // covers a frame tick plus the output pipe
    localparam int unsigned DIR_ROWS = 42;

    // modes the block leaves unused
    localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] white;
        logic              last;
    } pixel_t;

    typedef enum logic {ROW_CFG, ROW_TICK} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  restart;
        logic                  check_first;  // first pixel of the frame typed in below
        pixel_t                first;
    } stim_row_t;

    localparam pixel_t NO_PIX = '0;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_restart;
    logic                  m_valid;
    logic                  m_ready;
    logic [IDX_W-1:0]      m_pixel_index;
    logic [CHAN_W-1:0]     m_red_level;
    logic [CHAN_W-1:0]     m_green_level;
    logic [CHAN_W-1:0]     m_blue_level;
    logic [CHAN_W-1:0]     m_white_level;
    logic                  m_last_pixel;

    // predictor copy of the registers and effect counters
    logic [MODE_W-1:0]  cfg_mode;
    logic [COUNT_W-1:0] cfg_count;
    logic [COLOR_W-1:0] cfg_color;
    logic [7:0]         cfg_bright;
    logic [7:0]         hue;
    logic [7:0]         hue255;
    logic [1:0]         phase;
    logic [5:0]         pulse;

    pixel_t    pending_pixels[$];
    stim_row_t dir_rows[DIR_ROWS];

    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned err_count;
    int unsigned pixels_seen;
    int unsigned frames_sent;
    int unsigned reg_writes;
    bit          in_flight;

    led_strip_effect_generator DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_index (m_pixel_index),
        .m_red_level   (m_red_level),
        .m_green_level (m_green_level),
        .m_blue_level  (m_blue_level),
        .m_white_level (m_white_level),
        .m_last_pixel  (m_last_pixel)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // color ramp: green->red, then blue, then back to green
    function automatic logic [COLOR_W-1:0] color_wheel(input logic [7:0] pos);
        logic [7:0] ramp;
        if (pos < WHEEL_SEG1) begin
            ramp = 8'(pos * 3);
            return {ramp, 8'(FULL_SCALE - ramp), 16'd0};
        end
        if (pos < WHEEL_SEG2) begin
            ramp = 8'((pos - WHEEL_SEG1) * 3);
            return {8'(FULL_SCALE - ramp), 8'd0, ramp, 8'd0};
        end
        ramp = 8'((pos - WHEEL_SEG2) * 3);
        return {8'd0, ramp, 8'(FULL_SCALE - ramp), 8'd0};
    endfunction

    function automatic logic [COLOR_W-1:0] scale_rgbw(input logic [COLOR_W-1:0] rgbw,
                                                      input logic [7:0] gain);
        logic [COLOR_W-1:0] acc;
        logic [15:0]        wide;
        acc = '0;
        for (int b = 0; b < COLOR_W; b += 8) begin
            wide = 16'(rgbw[b +: 8]) * 16'(gain);
            acc[b +: 8] = wide[15:8];
        end
        return acc;
    endfunction

    // upper bits beyond the register width are don't-care, fill them sometimes
    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] val,
                                                        input int unsigned width);
        if ($urandom_range(3) == 0) begin
            return (32'($urandom) << width) | val;
        end
        return val;
    endfunction

    // one frame tick: restart and chase step, queue the pixel words it produces, then advance counters
    task automatic render_frame(input logic clear);
        int unsigned cnt;
        int unsigned pulse_gap;
        logic [7:0]  level;
        logic [COLOR_W-1:0] rgbw;
        pixel_t      px;
        if (clear) begin
            hue    = '0;
            hue255 = '0;
            phase  = '0;
            pulse  = '0;
        end
        cnt = (cfg_count > MAX_PIXELS_DEF) ? MAX_PIXELS_DEF : cfg_count;
        if (cfg_mode == MODE_CHASE || cfg_mode == MODE_CHASE_RB) begin
            phase = (phase >= CHASE_LAST) ? 2'd0 : phase + 2'd1;
        end
        pulse_gap = (pulse > PULSE_MID) ? pulse - PULSE_MID : PULSE_MID - pulse;
        level     = 8'((pulse_gap + 1) * PULSE_GAIN);
        for (int unsigned i = 0; i < cnt; i++) begin
            case (cfg_mode)
                MODE_RAINBOW:  rgbw = color_wheel(8'(i + hue));
                MODE_CYCLE:    rgbw = color_wheel(8'(i * 256 / cnt + hue));
                MODE_CHASE:    rgbw = (i % 3 == phase) ? cfg_color : '0;
                MODE_CHASE_RB: rgbw = (i % 3 == phase) ?
                                      color_wheel(8'((i + hue255) % FULL_SCALE)) : '0;
                MODE_STROBE:   rgbw = hue[0] ? '0 : cfg_color;
                MODE_PULSE:    rgbw = scale_rgbw(cfg_color, level);
                default:       rgbw = '0;
            endcase
            if (cfg_bright != FULL_SCALE) begin
                rgbw = scale_rgbw(rgbw, cfg_bright);
            end
            px.idx   = i[IDX_W-1:0];
            px.red   = rgbw[31:24];
            px.green = rgbw[23:16];
            px.blue  = rgbw[15:8];
            px.white = rgbw[7:0];
            px.last  = (i + 1 == cnt);
            pending_pixels.push_back(px);
        end
        hue    = hue + 8'd1;
        hue255 = (hue255 >= HUE255_LAST) ? 8'd0 : hue255 + 8'd1;
        pulse  = (pulse >= PULSE_LAST) ? 6'd0 : pulse + 6'd1;
    endtask

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("word %0d %s got %0h expected %0h",
                                      pixels_seen, name, got, want));
        end
    endtask

    // drop valid, wait for the last frame to drain and the sequencer to settle
    task automatic wait_quiet();
        if (in_flight) begin
            @(negedge aclk);
            s_valid = 1'b0;
            while (pending_pixels.size() != 0) @(negedge aclk);
            repeat (SETTLE) @(negedge aclk);
            in_flight = 1'b0;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            CFG_MODE:   cfg_mode   = val[MODE_W-1:0];
            CFG_COUNT:  cfg_count  = val[COUNT_W-1:0];
            CFG_COLOR:  cfg_color  = val[COLOR_W-1:0];
            CFG_BRIGHT: cfg_bright = val[7:0];
            default:    ;
        endcase
        reg_writes++;
    endtask

    task automatic send_tick(input logic clear, input logic check_first, input pixel_t first);
        int unsigned base;
        @(negedge aclk);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid   = 1'b0;
            s_restart = 1'($urandom);
            @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_restart = clear;
        do @(posedge aclk); while (s_ready !== 1'b1);
        base = pending_pixels.size();
        render_frame(clear);
        if (check_first && pending_pixels.size() > base) begin
            pending_pixels[base] = first;
        end
        frames_sent++;
        in_flight = 1'b1;
    endtask

    // receiver back-pressure
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel word, index %0d", m_pixel_index));
            end else begin
                want = pending_pixels.pop_front();
                check_field("pixel_index", 32'(m_pixel_index), 32'(want.idx));
                check_field("red_level", 32'(m_red_level), 32'(want.red));
                check_field("green_level", 32'(m_green_level), 32'(want.green));
                check_field("blue_level", 32'(m_blue_level), 32'(want.blue));
                check_field("white_level", 32'(m_white_level), 32'(want.white));
                check_field("last_pixel", 32'(m_last_pixel), 32'(want.last));
            end
            pixels_seen++;
        end
    end

    initial begin
        int unsigned src_pcts[4]  = '{0, 62, 0, 16};
        int unsigned sink_pcts[4] = '{0, 0, 62, 16};
        int unsigned sent;
        int unsigned burst;
        int unsigned sel;
        logic [MODE_W-1:0]  mode_pick;
        logic [COUNT_W-1:0] count_pick;
        logic [7:0]         bright_pick;

        dir_rows = '{
            '{ROW_TICK, CFG_MODE,   32'd0,            1'b0, 1'b1,
              pixel_t'{6'd0, 8'd0, 8'd255, 8'd0, 8'd0, 1'b0}},
            '{ROW_TICK, CFG_MODE,   32'd0,            1'b0, 1'b0, NO_PIX},
            '{ROW_CFG,  CFG_COUNT,  32'd1,            1'b0, 1'b0, NO_PIX},
            '{ROW_TICK, CFG_MODE,   32'd0,            1'b1, 1'b1,
              pixel_t'{6'd0, 8'd0, 8'd255, 8'd0, 8'd0, 1'b1}},
            '{ROW_CFG,  CFG_MODE,   32'(MODE_CYCLE),  1'b0, 1'b0, NO_PIX},
            '{ROW_CFG,  CFG_COUNT,  32'd3,            1'b0, 1'b0, NO_PIX},
            '{ROW_TICK, CFG_MODE,   32'd0,            1'b0, 1'b0, NO_PIX},
            '{ROW_CFG,  CFG_MODE,   32'(MODE_CHASE),  1'b0, 1'b0, NO_PIX},
            '{ROW_CFG,  CFG_COLOR,  32'hFFFF_FFFF,    1'b0, 1'b0, NO_PIX},
            // restart, phase steps to one: pixel 0 stays dark
            '{ROW_TICK, CFG_MODE,   32'd0,            1'b1, 1'b1, NO_PIX},
            '{ROW_TICK, CFG_MODE,   32'd0,            1'b0, 1'b0, NO_PIX},
            '{ROW_TICK, CFG_MODE,   32'd0,            1'b0, 1'b0, NO_PIX},
            '{ROW_CFG,  CFG_MODE,   32'(MODE_CHASE_RB), 1'b0, 1'b0, NO_PIX},
            '{ROW_CFG,  CFG_COUNT,  32'd64,           1'b0, 1'b0, NO_PIX},
            '{ROW_TICK, CFG_MODE,   32'd0,            1'b0, 1'b0, NO_PIX},
            '{ROW_TICK, CFG_MODE,   32'd0,            1'b0, 1'b0, NO_PIX},
            '{ROW_CFG,  CFG_MODE,   32'(MODE_STROBE), 1'b0, 1'b0, NO_PIX},
            '{ROW_CFG,  CFG_COUNT,  32'd1,            1'b0, 1'b0, NO_PIX},
            '{ROW_CFG,  CFG_BRIGHT, 32'd0,            1'b0, 1'b0, NO_PIX},
            '{ROW_TICK, CFG_MODE,   32'd0,            1'b1, 1'b1,
              pixel_t'{6'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1}},
            '{ROW_CFG,  CFG_BRIGHT, 32'd255,          1'b0, 1'b0, NO_PIX},
            '{ROW_TICK, CFG_MODE,   32'd0,            1'b1, 1'b1,
              pixel_t'{6'd0, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1}},
            // odd step: strobe is dark
            '{ROW_TICK, CFG_MODE,   32'd0,            1'b0, 1'b1,
              pixel_t'{6'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1}},
            '{ROW_CFG,  CFG_MODE,   32'(MODE_PULSE),  1'b0, 1'b0, NO_PIX},
            '{ROW_TICK, CFG_MODE,   32'd0,            1'b1, 1'b1,
              pixel_t'{6'd0, 8'd239, 8'd239, 8'd239, 8'd239, 1'b1}},
            '{ROW_CFG,  CFG_BRIGHT, 32'd128,          1'b0, 1'b0, NO_PIX},
            '{ROW_TICK, CFG_MODE,   32'd0,            1'b1, 1'b1,
              pixel_t'{6'd0, 8'd119, 8'd119, 8'd119, 8'd119, 1'b1}},
            '{ROW_TICK, CFG_MODE,   32'd0,            1'b0, 1'b0, NO_PIX},
            '{ROW_CFG,  CFG_COLOR,  32'hA5C3_0F81,    1'b0, 1'b0, NO_PIX},
            '{ROW_TICK, CFG_MODE,   32'd0,            1'b0, 1'b0, NO_PIX},
            '{ROW_CFG,  CFG_MODE,   32'(MODE_SPARE6), 1'b0, 1'b0, NO_PIX},
            '{ROW_TICK, CFG_MODE,   32'd0,            1'b0, 1'b1,
              pixel_t'{6'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1}},
            '{ROW_CFG,  CFG_MODE,   32'(MODE_SPARE7), 1'b0, 1'b0, NO_PIX},
            '{ROW_TICK, CFG_MODE,   32'd0,            1'b0, 1'b1,
              pixel_t'{6'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1}},
            '{ROW_CFG,  CFG_MODE,   32'(MODE_RAINBOW), 1'b0, 1'b0, NO_PIX},
            // empty strip: no words, counters still move
            '{ROW_CFG,  CFG_COUNT,  32'd0,            1'b0, 1'b0, NO_PIX},
            '{ROW_TICK, CFG_MODE,   32'd0,            1'b0, 1'b0, NO_PIX},
            '{ROW_CFG,  CFG_COUNT,  32'd127,          1'b0, 1'b0, NO_PIX},
            '{ROW_TICK, CFG_MODE,   32'd0,            1'b0, 1'b0, NO_PIX},
            '{ROW_CFG,  CFG_COUNT,  32'd65,           1'b0, 1'b0, NO_PIX},
            '{ROW_TICK, CFG_MODE,   32'd0,            1'b0, 1'b0, NO_PIX},
            '{ROW_CFG,  CFG_BRIGHT, 32'd255,          1'b0, 1'b0, NO_PIX}
        };

        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_MODE;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_restart      = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        err_count      = 0;
        pixels_seen    = 0;
        frames_sent    = 0;
        reg_writes     = 0;
        in_flight      = 1'b0;
        cfg_mode       = MODE_RAINBOW;
        cfg_count      = RESET_COUNT;
        cfg_color      = '0;
        cfg_bright     = RESET_BRIGHT;
        hue            = '0;
        hue255         = '0;
        phase          = '0;
        pulse          = '0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                wait_quiet();
                write_reg(dir_rows[r].reg_idx, dir_rows[r].data);
            end else begin
                send_tick(dir_rows[r].restart, dir_rows[r].check_first, dir_rows[r].first);
            end
        end

        // random bursts; restart is rare so the step counters get to wrap
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct   = src_pcts[ph];
            sink_stall_pct = sink_pcts[ph];
            sent = 0;
            while (sent < 52) begin
                wait_quiet();
                if ($urandom_range(15) == 0) begin
                    mode_pick = 3'($urandom_range(MODE_SPARE6, MODE_SPARE7));
                end else begin
                    mode_pick = 3'($urandom_range(MODE_RAINBOW, MODE_PULSE));
                end
                write_reg(CFG_MODE, with_junk(32'(mode_pick), MODE_W));
                if ($urandom_range(1) == 0) begin
                    sel = $urandom_range(19);
                    if (sel < 12) begin
                        count_pick = 7'($urandom_range(1, 8));
                    end else if (sel < 16) begin
                        count_pick = 7'($urandom_range(9, 64));
                    end else if (sel < 17) begin
                        count_pick = '0;
                    end else begin
                        count_pick = 7'($urandom_range(65, 127));
                    end
                    write_reg(CFG_COUNT, with_junk(32'(count_pick), COUNT_W));
                end
                if ($urandom_range(1) == 0) begin
                    sel = $urandom_range(7);
                    write_reg(CFG_COLOR, (sel == 0) ? 32'hFFFF_FFFF :
                                         (sel == 1) ? 32'd0 : 32'($urandom));
                end
                if ($urandom_range(1) == 0) begin
                    sel = $urandom_range(7);
                    bright_pick = (sel < 3) ? FULL_SCALE :
                                  (sel == 3) ? 8'd0 : 8'($urandom);
                    write_reg(CFG_BRIGHT, with_junk(32'(bright_pick), 8));
                end
                burst = $urandom_range(3, 12);
                repeat (burst) begin
                    send_tick($urandom_range(127) == 0, 1'b0, NO_PIX);
                end
                sent += burst;
            end
        end

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        wait_quiet();

        $display("covered %0d frame ticks across all effect modes and %0d register writes",
                 frames_sent, reg_writes);
        $display("%0d pixel words compared under four idle/stall mixes, %0d mismatches",
                 pixels_seen, err_count);
        if (err_count == 0 && pending_pixels.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial begin
        #(CLK_HALF * 2 * 600000);
        $display("timeout with %0d pixel words outstanding", pending_pixels.size());
        $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/lseg_pkg.sv
src/lseg_ctrl.sv
src/lseg_dp.sv
src/led_strip_effect_generator.sv
verif/led_strip_effect_generator_tb.sv
